/* src/kaf_pkg.sv */
// ----------------------------------------------------------------------------
// kaf_pkg
// Shared types and constants of the angle/gyro-bias Kalman filter.
// ----------------------------------------------------------------------------
package kaf_pkg;

  localparam int unsigned NumAxesDefault = 3;
  localparam int unsigned RegWidth       = 31;
  localparam int unsigned NumRegs        = 5;
  localparam int unsigned AddrWidth      = 5;
  localparam int unsigned DivBits        = 62;

  localparam logic signed [31:0] Q30One   = 32'sd1073741824;
  localparam logic signed [31:0] CompStep = 32'sd5368709;

  // register indexes
  localparam logic [2:0] RegNoiseAngle = 3'd0;
  localparam logic [2:0] RegNoiseBias  = 3'd1;
  localparam logic [2:0] RegMeasNoise  = 3'd2;
  localparam logic [2:0] RegTimeStep   = 3'd3;
  localparam logic [2:0] RegBlendWt    = 3'd4;

  // control of the shared multiply/add unit
  typedef struct packed {
    logic use_mul;  // add the rounded product instead of operand b
    logic use_acc;  // fold the accumulated product into the rounding
    logic sub;      // subtract instead of add
    logic acc_ld;   // move product into accumulator
  } mac_ctl_t;

  // saturate a 37-bit sum to 32 bits
  function automatic logic [32:0] sat32(input logic signed [36:0] v);
    logic [32:0] r;
    if (v > 37'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < -37'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

/* src/kaf_mac.sv */
// ----------------------------------------------------------------------------
// kaf_mac
// Shared 32x32 multiplier with Q2.30 rounding, accumulator and saturating add.
// ----------------------------------------------------------------------------
module kaf_mac
  import kaf_pkg::*;
(
  input  logic               clk_i,
  input  logic               ld_i,
  input  mac_ctl_t           ctl_i,
  input  logic signed [33:0] x_i,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] c_i,
  output logic signed [31:0] y_o,
  output logic               sat_o,
  output logic signed [36:0] raw_o
);

  logic signed [63:0] prod_q;
  logic signed [63:0] acc_q;
  logic signed [63:0] rnd;
  logic signed [35:0] ym;
  logic signed [35:0] yv;
  logic [32:0]        st;

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      prod_q <= 64'(b_i) * 64'(c_i);
    end
    if (ctl_i.acc_ld) begin
      acc_q <= prod_q;
    end
  end

  // round half up: add 2^29 then floor shift by 30
  always_comb begin
    rnd = prod_q + (ctl_i.use_acc ? acc_q : 64'sd0) + 64'sd536870912;
    ym  = 36'(rnd >>> 30);
    yv  = ctl_i.use_mul ? ym : 36'(b_i);
    raw_o = 37'(x_i) + (ctl_i.sub ? -37'(yv) : 37'(yv));
    st    = sat32(raw_o);
    y_o   = st[31:0];
    sat_o = st[32];
  end

endmodule

/* src/kaf_div.sv */
// ----------------------------------------------------------------------------
// kaf_div
// Radix-2 restoring divider for the gain, (p * 2^30) / e truncated to zero.
// ----------------------------------------------------------------------------
module kaf_div
  import kaf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [33:0] den_i,
  output logic               done_o,
  output logic signed [31:0] q_o,
  output logic               ovf_o
);

  localparam int unsigned CntWidth = $clog2(DivBits);

  logic                busy_q;
  logic                done_q;
  logic [CntWidth-1:0] cnt_q;
  logic [DivBits-1:0]  num_q;
  logic [33:0]         rem_q;
  logic [32:0]         den_q;
  logic                neg_q;
  logic                zero_q;

  logic [31:0] num_mag;
  logic [33:0] den_mag;
  logic [34:0] sh;
  logic        ge;

  assign num_mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign den_mag = den_i[33] ? 34'(-den_i) : 34'(den_i);
  assign sh      = {rem_q, num_q[DivBits-1]};
  assign ge      = sh >= {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntWidth'(DivBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= {num_mag, 30'b0};
      rem_q  <= '0;
      den_q  <= den_mag[32:0];
      neg_q  <= num_i[31] ^ den_i[33];
      zero_q <= (den_i == '0);
    end else if (busy_q) begin
      rem_q <= ge ? 34'(sh - {2'b00, den_q}) : sh[33:0];
      num_q <= {num_q[DivBits-2:0], ge};
    end
  end

  // quotient magnitude sits in num_q once done
  always_comb begin
    q_o   = '0;
    ovf_o = 1'b0;
    if (!zero_q) begin
      if (!neg_q) begin
        ovf_o = (num_q[DivBits-1:31] != '0);
        q_o   = ovf_o ? 32'sh7fff_ffff : $signed(num_q[31:0]);
      end else begin
        ovf_o = (num_q[DivBits-1:32] != '0) || (num_q[31] && (num_q[30:0] != '0));
        q_o   = ovf_o ? 32'sh8000_0000 : $signed(-num_q[31:0]);
      end
    end
  end

  assign done_o = done_q;

endmodule

/* src/imu_angle_kalman_filter.sv */
// ----------------------------------------------------------------------------
// imu_angle_kalman_filter
// Per-axis angle and gyro-bias Kalman filter with complementary-filter mode.
// ----------------------------------------------------------------------------
// One item is worked at a time by a step sequencer around one shared
// multiply/add unit and one restoring divider. Each sequencer step has a
// multiply phase, then an add and write back phase; the two gain steps
// start the divider, run its iterations and take the quotient. A Kalman
// item (cmd 0) and a complementary item (cmd 1) each run their own steps,
// and an item for an axis out of range goes straight to the done state.
// Input ready returns with the result, so a new item is not accepted
// before the last one has its result registered; a result still waiting in
// the output register holds the block in its done state until it is taken.
// Input ready is high only while no item is in work.
module imu_angle_kalman_filter
  import kaf_pkg::*;
#(
  parameter int unsigned NUM_AXES = NumAxesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // stream in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,  // measured_angle, gyro_rate
  input  logic [2:0]           s_axis_tuser,  // cmd, axis
  // stream out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,  // angle_estimate, rate_estimate
  output logic [2:0]           m_axis_tuser,  // out_axis, saturated
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned AxW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef enum logic [4:0] {
    S_RATE = 5'd0,  S_ANG  = 5'd1,  S_PDA  = 5'd2,  S_PDB  = 5'd3,
    S_P00  = 5'd4,  S_P01  = 5'd5,  S_P10  = 5'd6,  S_P11  = 5'd7,
    S_ERR  = 5'd8,  S_E    = 5'd9,  S_K0   = 5'd10, S_K1   = 5'd11,
    S_C00  = 5'd12, S_C01  = 5'd13, S_C10  = 5'd14, S_C11  = 5'd15,
    S_UA   = 5'd16, S_UB   = 5'd17, S_LR   = 5'd18, S_PRED = 5'd19,
    S_WM   = 5'd20, S_WP   = 5'd21
  } step_e;

  // registers
  logic [RegWidth-1:0] pna_q, pnb_q, mn_q, dt_q, bw_q;

  // per-axis state
  logic signed [31:0] angle_q [NUM_AXES];
  logic signed [31:0] bias_q  [NUM_AXES];
  logic signed [31:0] caa_q   [NUM_AXES];
  logic signed [31:0] cab_q   [NUM_AXES];
  logic signed [31:0] cba_q   [NUM_AXES];
  logic signed [31:0] cbb_q   [NUM_AXES];
  logic signed [31:0] lrate_q [NUM_AXES];

  // item in work
  state_e             state_q;
  step_e              step_q;
  logic               phase_q;
  logic               cmd_q, oor_q, sat_q;
  logic [1:0]         axis_q;
  logic signed [31:0] meas_q, gyro_q;
  logic [AxW-1:0]     idx;

  // working values
  logic signed [31:0] rate_q, ang_q, pd0_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [31:0] err_q, k0_q, k1_q, pred_q;
  logic signed [33:0] tmp_q, e_q;

  // output register
  logic        m_valid_q;
  logic [63:0] m_data_q;
  logic [2:0]  m_user_q;

  // datapath hookup
  mac_ctl_t           mctl;
  logic signed [33:0] mx;
  logic signed [31:0] mb, mc;
  logic signed [31:0] my;
  logic               msat;
  logic signed [36:0] mraw;
  logic               div_start, div_done, div_ovf;
  logic signed [31:0] div_num, div_q;
  logic               is_div, commit, last_step, in_acc;
  logic signed [31:0] w, winv;

  assign idx    = AxW'(axis_q);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign w      = ({1'b0, bw_q} > 32'(Q30One)) ? Q30One : $signed({1'b0, bw_q});
  assign winv   = Q30One - w;

  kaf_mac u_mac (
    .clk_i (clk_i),
    .ld_i  (state_q == ST_RUN && !phase_q),
    .ctl_i (mctl),
    .x_i   (mx),
    .b_i   (mb),
    .c_i   (mc),
    .y_o   (my),
    .sat_o (msat),
    .raw_o (mraw)
  );

  kaf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (e_q),
    .done_o  (div_done),
    .q_o     (div_q),
    .ovf_o   (div_ovf)
  );

  // operand selection per step
  always_comb begin
    mctl    = '0;
    mx      = '0;
    mb      = '0;
    mc      = '0;
    is_div  = 1'b0;
    div_num = p00_q;
    unique case (step_q)
      S_RATE: begin mx = 34'(gyro_q); mb = bias_q[idx]; mctl.sub = 1'b1; end
      S_ANG: begin
        mx = 34'(angle_q[idx]); mb = rate_q; mc = $signed({1'b0, dt_q});
        mctl.use_mul = 1'b1;
      end
      S_PDA: begin mx = $signed({3'b000, pna_q}); mb = cab_q[idx]; mctl.sub = 1'b1; end
      S_PDB: begin mx = tmp_q; mb = cba_q[idx]; mctl.sub = 1'b1; end
      S_P00: begin
        mx = 34'(caa_q[idx]); mb = pd0_q; mc = $signed({1'b0, dt_q});
        mctl.use_mul = 1'b1;
      end
      S_P01: begin
        mx = 34'(cab_q[idx]); mb = cbb_q[idx]; mc = $signed({1'b0, dt_q});
        mctl.use_mul = 1'b1; mctl.sub = 1'b1;
      end
      S_P10: begin
        mx = 34'(cba_q[idx]); mb = cbb_q[idx]; mc = $signed({1'b0, dt_q});
        mctl.use_mul = 1'b1; mctl.sub = 1'b1;
      end
      S_P11: begin
        mx = 34'(cbb_q[idx]); mb = $signed({1'b0, pnb_q}); mc = $signed({1'b0, dt_q});
        mctl.use_mul = 1'b1;
      end
      S_ERR: begin mx = 34'(meas_q); mb = ang_q; mctl.sub = 1'b1; end
      S_E:   begin mx = $signed({3'b000, mn_q}); mb = p00_q; end
      S_K0:  begin is_div = 1'b1; div_num = p00_q; end
      S_K1:  begin is_div = 1'b1; div_num = p10_q; end
      S_C00: begin
        mx = 34'(p00_q); mb = k0_q; mc = p00_q; mctl.use_mul = 1'b1; mctl.sub = 1'b1;
      end
      S_C01: begin
        mx = 34'(p01_q); mb = k0_q; mc = p01_q; mctl.use_mul = 1'b1; mctl.sub = 1'b1;
      end
      S_C10: begin
        mx = 34'(p10_q); mb = k1_q; mc = p00_q; mctl.use_mul = 1'b1; mctl.sub = 1'b1;
      end
      S_C11: begin
        mx = 34'(p11_q); mb = k1_q; mc = p01_q; mctl.use_mul = 1'b1; mctl.sub = 1'b1;
      end
      S_UA: begin mx = 34'(ang_q); mb = k0_q; mc = err_q; mctl.use_mul = 1'b1; end
      S_UB: begin mx = 34'(bias_q[idx]); mb = k1_q; mc = err_q; mctl.use_mul = 1'b1; end
      S_LR: begin mx = 34'(gyro_q); mb = bias_q[idx]; mctl.sub = 1'b1; end
      S_PRED: begin
        mx = 34'(angle_q[idx]); mb = gyro_q; mc = CompStep; mctl.use_mul = 1'b1;
      end
      S_WM: begin mb = w; mc = meas_q; mctl.acc_ld = phase_q; end
      S_WP: begin mb = winv; mc = pred_q; mctl.use_mul = 1'b1; mctl.use_acc = 1'b1; end
      default: begin mctl = '0; end
    endcase
  end

  assign div_start = (state_q == ST_RUN) && is_div && !phase_q;
  assign commit    = (state_q == ST_RUN) && phase_q && (!is_div || div_done);
  assign last_step = (step_q == S_LR) || (step_q == S_WP);

  // sequencer and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= S_RATE;
      phase_q   <= 1'b0;
      sat_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            sat_q   <= 1'b0;
            phase_q <= 1'b0;
            step_q  <= s_axis_tuser[0] ? S_PRED : S_RATE;
            state_q <= (32'(s_axis_tuser[2:1]) >= 32'(NUM_AXES)) ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          if (!phase_q) begin
            phase_q <= 1'b1;
          end else if (commit) begin
            phase_q <= 1'b0;
            if ((step_q != S_PDA) && (step_q != S_E) && (step_q != S_WM)) begin
              sat_q <= sat_q | (is_div ? div_ovf : msat);
            end
            if (last_step) begin
              state_q <= ST_DONE;
            end else begin
              step_q <= step_e'(step_q + 5'd1);
            end
          end
        end
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= s_axis_tuser[0];
      axis_q <= s_axis_tuser[2:1];
      oor_q  <= (32'(s_axis_tuser[2:1]) >= 32'(NUM_AXES));
      meas_q <= $signed(s_axis_tdata[31:0]);
      gyro_q <= $signed(s_axis_tdata[63:32]);
    end
    if (commit) begin
      case (step_q)
        S_RATE: rate_q <= my;
        S_ANG:  ang_q  <= my;
        S_PDA:  tmp_q  <= mraw[33:0];
        S_PDB:  pd0_q  <= my;
        S_P00:  p00_q  <= my;
        S_P01:  p01_q  <= my;
        S_P10:  p10_q  <= my;
        S_P11:  p11_q  <= my;
        S_ERR:  err_q  <= my;
        S_E:    e_q    <= mraw[33:0];
        S_K0:   k0_q   <= div_q;
        S_K1:   k1_q   <= div_q;
        S_UA:   ang_q  <= my;
        S_PRED: pred_q <= my;
        default: ;
      endcase
    end
    if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
      m_user_q <= {sat_q & ~oor_q, axis_q};
      m_data_q <= oor_q ? 64'b0 : {lrate_q[idx], angle_q[idx]};
    end
  end

  // per-axis state and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pna_q <= RegWidth'(1073742);
      pnb_q <= RegWidth'(3221225);
      mn_q  <= RegWidth'(536870912);
      dt_q  <= RegWidth'(5368709);
      bw_q  <= RegWidth'(21474836);
      for (int i = 0; i < NUM_AXES; i++) begin
        angle_q[i] <= '0;
        bias_q[i]  <= '0;
        caa_q[i]   <= Q30One;
        cab_q[i]   <= '0;
        cba_q[i]   <= '0;
        cbb_q[i]   <= Q30One;
        lrate_q[i] <= '0;
      end
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[4:2])
          RegNoiseAngle: pna_q <= pwdata[RegWidth-1:0];
          RegNoiseBias:  pnb_q <= pwdata[RegWidth-1:0];
          RegMeasNoise:  mn_q  <= pwdata[RegWidth-1:0];
          RegTimeStep:   dt_q  <= pwdata[RegWidth-1:0];
          RegBlendWt:    bw_q  <= pwdata[RegWidth-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        case (step_q)
          S_C00: caa_q[idx]   <= my;
          S_C01: cab_q[idx]   <= my;
          S_C10: cba_q[idx]   <= my;
          S_C11: cbb_q[idx]   <= my;
          S_UA:  angle_q[idx] <= my;
          S_UB:  bias_q[idx]  <= my;
          S_LR:  lrate_q[idx] <= my;
          S_WP:  angle_q[idx] <= my;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegNoiseAngle: prdata = {1'b0, pna_q};
      RegNoiseBias:  prdata = {1'b0, pnb_q};
      RegMeasNoise:  prdata = {1'b0, mn_q};
      RegTimeStep:   prdata = {1'b0, dt_q};
      RegBlendWt:    prdata = {1'b0, bw_q};
      default:       prdata = '0;
    endcase
  end

  assign pready        = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // divider finishes only inside a gain step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_RUN) && (step_q == S_K0 || step_q == S_K1))
    else $error("divider done outside gain step");

  // a result appears only after the sequencer reached its end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_DONE)
    else $error("result without finished item");

  // no second item while one is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("item accepted while busy");

  // complementary items never touch the divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cmd_q) |-> !div_start)
    else $error("divider started for complementary item");

endmodule
